FILE: hdl/sbot_pkg.sv
package sbot_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENT_SETUP,
        ST_ENT_START,
        ST_ENT_WAIT,
        ST_EXT_SETUP,
        ST_EXT_START,
        ST_EXT_WAIT,
        ST_FINISH
    } sbot_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input word
        logic setup;       // register gap flags, numerator and slack for one phase
        logic exit_phase;  // 0: entry time, 1: exit time
        logic div_start;   // launch the divider
        logic take;        // fold the phase result into the running state
        logic emit;        // load the result word and clear the running state
    } sbot_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic need_div;    // this phase has a gap that does close
        logic div_done;    // quotient is ready
        logic last;        // captured word closes the box pair
        logic out_full;    // result register holds a word that is stalled
    } sbot_sts_t;

endpackage

FILE: hdl/sbot_div.sv
module sbot_div
    import sbot_pkg::*;
#(
    parameter int NUM_WIDTH = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [NUM_WIDTH:0]   den,
    output logic                 done,
    output logic [FRAC_BITS:0]   quo
);

    localparam int RemWidth = NUM_WIDTH + 2;
    localparam int CntWidth = $clog2(FRAC_BITS + 1);

    logic [RemWidth-1:0]  rem_reg, rem_next;
    logic [NUM_WIDTH:0]   den_reg, den_next;
    logic [FRAC_BITS:0]   quo_reg, quo_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [RemWidth-1:0]  trial;
    logic [RemWidth-1:0]  den_ext;
    logic [RemWidth-1:0]  diff;
    logic                 fits;

    // Restoring step: first step compares without a shift
    always_comb
    begin
        den_ext = {1'b0, den_reg};
        trial   = (cnt_reg == '0) ? rem_reg : {rem_reg[RemWidth-2:0], 1'b0};
        fits    = trial >= den_ext;
        diff    = trial - den_ext;
    end

    // Advance one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {2'b00, num};
            den_next  = den;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff : trial;
            quo_next = {quo_reg[FRAC_BITS-1:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntWidth'(FRAC_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    // Numerator never exceeds denominator, so the quotient is at most one
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (quo_reg <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("divider quotient above one");

endmodule

FILE: hdl/sbot_dp.sv
module sbot_dp
    import sbot_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int TIME_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbot_cmd_t                     cmd,
    output sbot_sts_t                     sts,
    input  logic signed [COORD_WIDTH-1:0] a_lo_start,
    input  logic signed [COORD_WIDTH-1:0] a_hi_start,
    input  logic signed [COORD_WIDTH-1:0] a_lo_end,
    input  logic signed [COORD_WIDTH-1:0] a_hi_end,
    input  logic signed [COORD_WIDTH-1:0] b_lo_start,
    input  logic signed [COORD_WIDTH-1:0] b_hi_start,
    input  logic signed [COORD_WIDTH-1:0] b_lo_end,
    input  logic signed [COORD_WIDTH-1:0] b_hi_end,
    input  logic                          last_axis,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          overlap,
    output logic [TIME_FRAC_BITS:0]       entry_time,
    output logic [TIME_FRAC_BITS:0]       exit_time
);

    localparam int TimeWidth = TIME_FRAC_BITS + 1;
    localparam logic [TimeWidth-1:0] TimeOne = {1'b1, {TIME_FRAC_BITS{1'b0}}};

    // Captured word
    logic signed [COORD_WIDTH-1:0] als_reg, ahs_reg, ale_reg, ahe_reg;
    logic signed [COORD_WIDTH-1:0] bls_reg, bhs_reg, ble_reg, bhe_reg;
    logic                          last_reg;

    // Phase setup results
    logic [COORD_WIDTH-1:0] num_reg, num_next;
    logic [COORD_WIDTH-1:0] slack_reg, slack_next;
    logic                   gap_reg, gap_next;
    logic                   never_reg, never_next;

    // Running state
    logic [TimeWidth-1:0]   run_entry_reg, run_entry_next;
    logic [TimeWidth-1:0]   run_exit_reg, run_exit_next;
    logic                   never_ovl_reg, never_ovl_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic                   overlap_reg, overlap_next;
    logic [TimeWidth-1:0]   entry_out_reg, entry_out_next;
    logic [TimeWidth-1:0]   exit_out_reg, exit_out_next;

    logic                          b_above, a_above;
    logic signed [COORD_WIDTH-1:0] los, loe, his, hie;
    logic signed [COORD_WIDTH:0]   diff_num, diff_slack;
    logic                          need_div;
    logic [COORD_WIDTH:0]          div_den;
    logic                          div_done;
    logic [TimeWidth-1:0]          div_quo;

    // Pick the gap sides for the current phase
    always_comb
    begin
        if (cmd.exit_phase)
        begin
            b_above = ble_reg > ahe_reg;
            a_above = ale_reg > bhe_reg;
        end
        else
        begin
            b_above = bls_reg > ahs_reg;
            a_above = als_reg > bhs_reg;
        end
        los = b_above ? ahs_reg : bhs_reg;
        loe = b_above ? ahe_reg : bhe_reg;
        his = b_above ? bls_reg : als_reg;
        hie = b_above ? ble_reg : ale_reg;
    end

    // Gap widths; both are non-negative whenever they are used
    always_comb
    begin
        if (cmd.exit_phase)
        begin
            diff_num   = {los[COORD_WIDTH-1], los} - {his[COORD_WIDTH-1], his};
            diff_slack = {hie[COORD_WIDTH-1], hie} - {loe[COORD_WIDTH-1], loe};
            never_next = los < his;
        end
        else
        begin
            diff_num   = {his[COORD_WIDTH-1], his} - {los[COORD_WIDTH-1], los};
            diff_slack = {loe[COORD_WIDTH-1], loe} - {hie[COORD_WIDTH-1], hie};
            never_next = loe < hie;
        end
        gap_next   = b_above | a_above;
        num_next   = diff_num[COORD_WIDTH-1:0];
        slack_next = diff_slack[COORD_WIDTH-1:0];
    end

    assign need_div = gap_reg & ~never_reg;
    assign div_den  = {1'b0, num_reg} + {1'b0, slack_reg};

    sbot_div #(
        .NUM_WIDTH (COORD_WIDTH),
        .FRAC_BITS (TIME_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Fold phase results into running state; clear it on emit
    always_comb
    begin
        run_entry_next = run_entry_reg;
        run_exit_next  = run_exit_reg;
        never_ovl_next = never_ovl_reg;
        if (cmd.take)
        begin
            if (gap_reg && never_reg)
            begin
                never_ovl_next = 1'b1;
            end
            if (need_div)
            begin
                if (cmd.exit_phase)
                begin
                    if (div_quo < run_exit_reg)
                    begin
                        run_exit_next = div_quo;
                    end
                end
                else if (div_quo > run_entry_reg)
                begin
                    run_entry_next = div_quo;
                end
            end
        end
        if (cmd.emit)
        begin
            run_entry_next = '0;
            run_exit_next  = TimeOne;
            never_ovl_next = 1'b0;
        end
    end

    // Load the result word; drop valid when taken
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        overlap_next   = overlap_reg;
        entry_out_next = entry_out_reg;
        exit_out_next  = exit_out_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (never_ovl_reg)
            begin
                overlap_next   = 1'b0;
                entry_out_next = TimeOne;
                exit_out_next  = '0;
            end
            else
            begin
                overlap_next   = run_entry_reg <= run_exit_reg;
                entry_out_next = run_entry_reg;
                exit_out_next  = run_exit_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_entry_reg <= '0;
            run_exit_reg  <= TimeOne;
            never_ovl_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_entry_reg <= run_entry_next;
            run_exit_reg  <= run_exit_next;
            never_ovl_reg <= never_ovl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            als_reg  <= a_lo_start;
            ahs_reg  <= a_hi_start;
            ale_reg  <= a_lo_end;
            ahe_reg  <= a_hi_end;
            bls_reg  <= b_lo_start;
            bhs_reg  <= b_hi_start;
            ble_reg  <= b_lo_end;
            bhe_reg  <= b_hi_end;
            last_reg <= last_axis;
        end
        if (cmd.setup)
        begin
            num_reg   <= num_next;
            slack_reg <= slack_next;
            gap_reg   <= gap_next;
            never_reg <= never_next;
        end
        overlap_reg   <= overlap_next;
        entry_out_reg <= entry_out_next;
        exit_out_reg  <= exit_out_next;
    end

    always_comb
    begin
        sts.need_div = need_div;
        sts.div_done = div_done;
        sts.last     = last_reg;
        sts.out_full = out_valid_reg & out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign overlap    = overlap_reg;
    assign entry_time = entry_out_reg;
    assign exit_time  = exit_out_reg;

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result word not presented");

    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        (run_entry_reg <= TimeOne) && (run_exit_reg <= TimeOne))
        else $error("running time above one");

endmodule

FILE: hdl/sbot_ctrl.sv
module sbot_ctrl
    import sbot_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  sbot_sts_t sts,
    output sbot_cmd_t cmd
);

    sbot_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ENT_SETUP;
                end
            end
            ST_ENT_SETUP: state_next = ST_ENT_START;
            ST_ENT_START: state_next = sts.need_div ? ST_ENT_WAIT : ST_EXT_SETUP;
            ST_ENT_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EXT_SETUP;
                end
            end
            ST_EXT_SETUP: state_next = ST_EXT_START;
            ST_EXT_START: state_next = sts.need_div ? ST_EXT_WAIT : ST_FINISH;
            ST_EXT_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.last || !sts.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_ENT_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_ENT_START:
            begin
                cmd.div_start = sts.need_div;
                cmd.take      = ~sts.need_div;
            end
            ST_ENT_WAIT:
            begin
                cmd.take = sts.div_done;
            end
            ST_EXT_SETUP:
            begin
                cmd.setup      = 1'b1;
                cmd.exit_phase = 1'b1;
            end
            ST_EXT_START:
            begin
                cmd.exit_phase = 1'b1;
                cmd.div_start  = sts.need_div;
                cmd.take       = ~sts.need_div;
            end
            ST_EXT_WAIT:
            begin
                cmd.exit_phase = 1'b1;
                cmd.take       = sts.div_done;
            end
            ST_FINISH:
            begin
                cmd.emit = sts.last & ~sts.out_full;
            end
            default: cmd = '0;
        endcase
    end

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (sts.last && !sts.out_full))
        else $error("result emitted for a word not marked last");

endmodule

FILE: hdl/swept_box_overlap_time_top.sv
// An axis word goes from input accept through the entry setup, start and divider wait
// states, then the exit ones, then finish; a phase with no gap to divide skips its wait,
// and a stalled result word can hold finish. A new word is taken only in idle. The shared
// divider runs up to twice per word, one quotient bit a cycle, and a finished result waits
// in its register while the next word is taken. Reset (rst_n low, asynchronous) clears the
// running times to 0 and one, the no-overlap flag, the result valid and the controller.
module swept_box_overlap_time_top
    import sbot_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int TIME_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] a_lo_start,
    input  logic signed [COORD_WIDTH-1:0] a_hi_start,
    input  logic signed [COORD_WIDTH-1:0] a_lo_end,
    input  logic signed [COORD_WIDTH-1:0] a_hi_end,
    input  logic signed [COORD_WIDTH-1:0] b_lo_start,
    input  logic signed [COORD_WIDTH-1:0] b_hi_start,
    input  logic signed [COORD_WIDTH-1:0] b_lo_end,
    input  logic signed [COORD_WIDTH-1:0] b_hi_end,
    input  logic                          last_axis,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          overlap,
    output logic [TIME_FRAC_BITS:0]       entry_time,
    output logic [TIME_FRAC_BITS:0]       exit_time
);

    sbot_cmd_t cmd;
    sbot_sts_t sts;

    sbot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbot_dp #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .a_lo_start (a_lo_start),
        .a_hi_start (a_hi_start),
        .a_lo_end   (a_lo_end),
        .a_hi_end   (a_hi_end),
        .b_lo_start (b_lo_start),
        .b_hi_start (b_hi_start),
        .b_lo_end   (b_lo_end),
        .b_hi_end   (b_hi_end),
        .last_axis  (last_axis),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .overlap    (overlap),
        .entry_time (entry_time),
        .exit_time  (exit_time)
    );

endmodule
